### rtl/core/mos_pkg.sv
`default_nettype none

package mos_pkg;

  // Field widths
  localparam int unsigned COORD_W   = 7;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Segments one pixel can close, and depth of the segment-group queue
  localparam int unsigned NUM_SEGS    = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASK_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HEIGHT = 2'd1;

  typedef logic [COORD_W-1:0] coord_t;

  // Run kinds: leading edge is top or left, trailing edge is bottom or right
  typedef enum logic [1:0] {
    RUN_NONE  = 2'd0,
    RUN_LEAD  = 2'd1,
    RUN_TRAIL = 2'd2
  } run_kind_e;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } seg_t;

  // All segments closed by one pixel, in output order (bit 0 first)
  typedef struct packed {
    logic [NUM_SEGS-1:0] mask;
    seg_t [NUM_SEGS-1:0] seg;
  } seg_group_t;

  typedef struct packed {
    run_kind_e kind;
    coord_t    start;
  } col_run_t;

  // Line store request: write the current column, prefetch rd_col
  typedef struct packed {
    logic     en;
    coord_t   col;
    coord_t   rd_col;
    logic     above;
    col_run_t run;
  } ls_req_t;

  // Line store response for the current column
  typedef struct packed {
    logic     above;
    col_run_t run;
  } ls_rsp_t;

  // Map a register value to the size in use: zero acts as one, clamp at maxv
  function automatic coord_t eff_size(coord_t v, logic [8:0] maxv);
    coord_t r;
    if (v == '0) begin
      r = coord_t'(1);
    end else if ({2'b00, v} > maxv) begin
      r = maxv[COORD_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/mos_if.sv
`default_nettype none

// Pixel request channel
interface mos_pix_if import mos_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// Segment request channel
interface mos_seg_if import mos_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  logic   last_of_item;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, output last_of_item, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, input last_of_item, output ready);
endinterface

// Configuration write channel
interface mos_cfg_if import mos_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  coord_t               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/mos_line_store.sv
`default_nettype none

module mos_line_store import mos_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    clear_i,
  input  ls_req_t ls_req_i,
  output ls_rsp_t ls_rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic     row_mem [DEPTH];
  col_run_t col_mem [DEPTH];

  logic [DEPTH-1:0] valid_q, valid_d;
  logic             row_rd_q;
  col_run_t         col_rd_q;
  logic             vld_q, vld_d;
  logic             byp_q, byp_d;
  logic             byp_above_q;
  col_run_t         byp_run_q;

  logic [AW-1:0] wa;
  logic [AW-1:0] ra;

  assign wa = ls_req_i.col[AW-1:0];
  assign ra = ls_req_i.rd_col[AW-1:0];

  // Write the current column, read the column the next pixel needs
  always_ff @(posedge clk_i) begin
    if (ls_req_i.en) begin
      row_mem[wa] <= ls_req_i.above;
      col_mem[wa] <= ls_req_i.run;
    end
    row_rd_q    <= row_mem[ra];
    col_rd_q    <= col_mem[ra];
    byp_above_q <= ls_req_i.above;
    byp_run_q   <= ls_req_i.run;
  end

  // Track written entries; forward a write to the same column
  always_comb begin
    valid_d = valid_q;
    if (ls_req_i.en) begin
      valid_d[wa] = 1'b1;
    end
    vld_d = valid_q[ra];
    byp_d = ls_req_i.en && (ls_req_i.col == ls_req_i.rd_col);
    if (clear_i) begin
      valid_d = '0;
      vld_d   = 1'b0;
      byp_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      vld_q   <= vld_d;
      byp_q   <= byp_d;
    end
  end

  // Unwritten entries read as cleared
  always_comb begin
    if (byp_q) begin
      ls_rsp_o.above = byp_above_q;
      ls_rsp_o.run   = byp_run_q;
    end else if (vld_q) begin
      ls_rsp_o.above = row_rd_q;
      ls_rsp_o.run   = col_rd_q;
    end else begin
      ls_rsp_o.above = 1'b0;
      ls_rsp_o.run   = '{kind: RUN_NONE, start: '0};
    end
  end

endmodule

`default_nettype wire

### rtl/core/mos_front.sv
`default_nettype none

module mos_front import mos_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clear_i,
  input  coord_t     width_i,
  input  coord_t     height_i,
  mos_pix_if.sink    pix_i,
  output ls_req_t    ls_req_o,
  input  ls_rsp_t    ls_rsp_i,
  input  logic       q_full_i,
  output logic       push_o,
  output seg_group_t push_grp_o
);

  coord_t    col_q, col_d;
  coord_t    row_q, row_d;
  logic      left_q, left_d;
  run_kind_e rk_q, rk_d;
  coord_t    rs_q, rs_d;
  run_kind_e rbk_q, rbk_d;
  coord_t    rbs_q, rbs_d;

  logic      accept;
  logic      closing;
  logic      cur;
  logic      left;
  logic      last_col;
  run_kind_e hk;
  run_kind_e vk;
  run_kind_e rvk;
  run_kind_e rk1;
  coord_t    rs1;
  run_kind_e ck;
  coord_t    cs;
  run_kind_e ck1;
  coord_t    cs1;
  coord_t    nx;

  assign pix_i.ready = !q_full_i;
  assign accept      = pix_i.valid && !q_full_i;

  // Classify the pixel against its neighbors
  always_comb begin
    closing  = (row_q == height_i);
    cur      = !closing && (pix_i.pixel_value != '0);
    left     = (col_q == '0) ? 1'b0 : left_q;
    last_col = ((col_q + coord_t'(1)) == width_i);
    nx       = last_col ? '0 : col_q + coord_t'(1);
    ck       = ls_rsp_i.run.kind;
    cs       = ls_rsp_i.run.start;

    if (cur && !ls_rsp_i.above) begin
      hk = RUN_LEAD;
    end else if (ls_rsp_i.above && !cur) begin
      hk = RUN_TRAIL;
    end else begin
      hk = RUN_NONE;
    end

    if (cur && !left) begin
      vk = RUN_LEAD;
    end else if (left && !cur) begin
      vk = RUN_TRAIL;
    end else begin
      vk = RUN_NONE;
    end

    rvk = cur ? RUN_TRAIL : RUN_NONE;
  end

  // Close and open runs, collect the closed segments in output order
  always_comb begin
    push_grp_o = '0;

    // row run closing at this pixel
    rk1 = rk_q;
    rs1 = rs_q;
    if (hk != rk_q) begin
      push_grp_o.mask[0] = (rk_q != RUN_NONE);
      rk1 = hk;
      if (hk != RUN_NONE) begin
        rs1 = col_q;
      end
    end
    push_grp_o.seg[0] = '{sx: rs_q, sy: row_q, ex: col_q, ey: row_q};

    // column run closing at the boundary left of this pixel
    ck1 = ck;
    cs1 = cs;
    if (vk != ck) begin
      push_grp_o.mask[1] = (ck != RUN_NONE);
      ck1 = vk;
      if (vk != RUN_NONE) begin
        cs1 = row_q;
      end
    end
    push_grp_o.seg[1] = '{sx: col_q, sy: cs, ex: col_q, ey: row_q};

    // row run closing at the right border
    push_grp_o.mask[2] = last_col && (rk1 != RUN_NONE);
    push_grp_o.seg[2]  = '{sx: rs1, sy: row_q, ex: width_i, ey: row_q};

    // run on the right border boundary
    rbk_d = rbk_q;
    rbs_d = rbs_q;
    if (last_col && (rvk != rbk_q)) begin
      push_grp_o.mask[3] = (rbk_q != RUN_NONE);
      rbk_d = rvk;
      if (rvk != RUN_NONE) begin
        rbs_d = row_q;
      end
    end
    push_grp_o.seg[3] = '{sx: width_i, sy: rbs_q, ex: width_i, ey: row_q};

    push_o = accept && (push_grp_o.mask != '0);

    rk_d   = last_col ? RUN_NONE : rk1;
    rs_d   = rs1;
    left_d = last_col ? 1'b0 : cur;
    col_d  = nx;
    if (last_col) begin
      row_d = closing ? '0 : row_q + coord_t'(1);
    end else begin
      row_d = row_q;
    end
  end

  // Write back this column, prefetch the next one
  always_comb begin
    ls_req_o.en     = accept;
    ls_req_o.col    = col_q;
    ls_req_o.rd_col = accept ? nx : col_q;
    ls_req_o.above  = cur;
    ls_req_o.run    = '{kind: ck1, start: cs1};
  end

  // Advance the scan position and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= 1'b0;
      rk_q   <= RUN_NONE;
      rs_q   <= '0;
      rbk_q  <= RUN_NONE;
      rbs_q  <= '0;
    end else if (clear_i) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= 1'b0;
      rk_q   <= RUN_NONE;
      rs_q   <= '0;
      rbk_q  <= RUN_NONE;
      rbs_q  <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
      rk_q   <= rk_d;
      rs_q   <= rs_d;
      rbk_q  <= rbk_d;
      rbs_q  <= rbs_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mos_seg_queue.sv
`default_nettype none

module mos_seg_queue import mos_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  seg_group_t push_grp_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output seg_group_t head_o
);

  seg_group_t ent_q [QUEUE_DEPTH];

  logic [QUEUE_AW-1:0] wr_q;
  logic [QUEUE_AW-1:0] rd_q;
  logic [QUEUE_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = ent_q[rd_q];

  // Store pushed groups
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_grp_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QUEUE_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QUEUE_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QUEUE_AW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/mos_back.sv
`default_nettype none

module mos_back import mos_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  seg_group_t head_i,
  output logic       pop_o,
  mos_seg_if.source  seg_o
);

  logic [NUM_SEGS-1:0] rem_q, rem_d;
  seg_t [NUM_SEGS-1:0] grp_q, grp_d;
  logic                ovld_q, ovld_d;
  seg_t                oseg_q;
  logic                olast_q;

  logic                adv;
  logic [NUM_SEGS-1:0] sel;
  logic [NUM_SEGS-1:0] rem_after;
  seg_t                pick;

  // Pick the lowest pending segment of the current group
  always_comb begin
    adv       = !ovld_q || seg_o.ready;
    sel       = rem_q & (~rem_q + NUM_SEGS'(1));
    rem_after = adv ? (rem_q & ~sel) : rem_q;
    pick      = '0;
    for (int i = 0; i < NUM_SEGS; i++) begin
      if (sel[i]) begin
        pick = grp_q[i];
      end
    end
    ovld_d = adv ? (rem_q != '0) : ovld_q;

    // refill from the queue once the group is drained
    pop_o = (rem_after == '0) && !empty_i;
    rem_d = pop_o ? head_i.mask : rem_after;
    grp_d = pop_o ? head_i.seg : grp_q;
  end

  // Hold the group being drained and the output request
  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    if (adv) begin
      oseg_q  <= pick;
      olast_q <= ((rem_q & ~sel) == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      ovld_q <= ovld_d;
    end
  end

  assign seg_o.valid        = ovld_q;
  assign seg_o.start_x      = oseg_q.sx;
  assign seg_o.start_y      = oseg_q.sy;
  assign seg_o.end_x        = oseg_q.ex;
  assign seg_o.end_y        = oseg_q.ey;
  assign seg_o.last_of_item = olast_q;

endmodule

`default_nettype wire

### rtl/core/mask_outline_segments_top.sv
`default_nettype none

// Outline extractor for a binary brush mask. Pixels arrive in raster order on
// pix_i, followed by one closing row of mask_width requests whose values are
// ignored; a nonzero pixel is set. Each maximal straight outline edge leaves
// on seg_o as one segment with its end corners on the pixel-corner grid, in
// the order its run closes, and last_of_item marks the final segment caused
// by a pixel (a pixel may cause none and at most four). The front accepts one
// pixel per cycle whenever the four-entry segment-group queue has room; the
// output drains one segment per cycle while seg_o is ready, so the queue absorbs
// bursts. Per-column state sits in a line memory with a prefetch of the next
// column. Writing mask_width (index 0) or mask_height (index 1) restarts the
// frame; write them only while the block is idle. A value of 0 acts as 1 and
// a value above MAX_WIDTH or MAX_HEIGHT acts as that limit.
module mask_outline_segments_top import mos_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mos_cfg_if.sink    cfg_i,
  mos_pix_if.sink    pix_i,
  mos_seg_if.source  seg_o
);

  // Columns beyond the largest 7-bit width are never used
  localparam int unsigned CoordMax = (1 << COORD_W) - 1;
  localparam int unsigned Depth    = (MAX_WIDTH < CoordMax) ? MAX_WIDTH : CoordMax;

  localparam logic [8:0] MaxW = 9'(MAX_WIDTH);
  localparam logic [8:0] MaxH = 9'(MAX_HEIGHT);

  coord_t     width_q;
  coord_t     height_q;
  logic       cfg_wr;
  logic       clear;
  ls_req_t    ls_req;
  ls_rsp_t    ls_rsp;
  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  seg_group_t push_grp;
  seg_group_t head;

  // Take configuration writes; a known register restarts the frame
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign clear       = cfg_wr &&
                       ((cfg_i.index == REG_MASK_WIDTH) || (cfg_i.index == REG_MASK_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= coord_t'(1);
      height_q <= coord_t'(1);
    end else if (cfg_wr) begin
      if (cfg_i.index == REG_MASK_WIDTH) begin
        width_q <= eff_size(cfg_i.data, MaxW);
      end
      if (cfg_i.index == REG_MASK_HEIGHT) begin
        height_q <= eff_size(cfg_i.data, MaxH);
      end
    end
  end

  mos_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear),
    .width_i    (width_q),
    .height_i   (height_q),
    .pix_i      (pix_i),
    .ls_req_o   (ls_req),
    .ls_rsp_i   (ls_rsp),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_grp_o (push_grp)
  );

  mos_line_store #(
    .DEPTH (Depth)
  ) u_line_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (clear),
    .ls_req_i (ls_req),
    .ls_rsp_o (ls_rsp)
  );

  mos_seg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_grp_i (push_grp),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  mos_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (pop),
    .seg_o   (seg_o)
  );

endmodule

`default_nettype wire

### test/mask_outline_segments_top_tb.sv
`timescale 1ns / 100ps

module mask_outline_segments_top_tb;
  import mos_pkg::*;

  localparam int unsigned MAX_W = 64;
  localparam int unsigned MAX_H = 64;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT = 4000;

  // Register indexes that the block has no register behind
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   last;
  } outline_seg_t;

  logic clk_i;
  logic rst_ni;

  mos_cfg_if cfg_bus ();
  mos_pix_if pix_bus ();
  mos_seg_if seg_bus ();

  mask_outline_segments_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .pix_i  (pix_bus),
    .seg_o  (seg_bus)
  );

  // Segments the outline tracker predicts, oldest first
  outline_seg_t outline_q[$];
  int unsigned  fail_cnt;
  int unsigned  idle_pct;
  int unsigned  stall_pct;

  // Mirror of the block's registers and frame state
  coord_t    width_reg;
  coord_t    height_reg;
  logic      prev_row_set[MAX_W];
  int unsigned next_col;
  int unsigned next_row;
  logic      left_set;
  run_kind_e line_kind;
  coord_t    line_start;
  run_kind_e bound_kind[MAX_W+1];
  coord_t    bound_start[MAX_W+1];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_size(coord_t v, int unsigned lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return v;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i <= MAX_W; i++) begin
      if (i < MAX_W) prev_row_set[i] = 1'b0;
      bound_kind[i] = RUN_NONE;
      bound_start[i] = '0;
    end
    next_col = 0;
    next_row = 0;
    left_set = 1'b0;
    line_kind = RUN_NONE;
    line_start = '0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, coord_t data);
    if (idx == REG_MASK_WIDTH) begin
      width_reg = data;
      restart_frame();
    end else if (idx == REG_MASK_HEIGHT) begin
      height_reg = data;
      restart_frame();
    end
  endfunction

  // Leading edge when this pixel is set and its neighbor not, trailing when reversed
  function automatic run_kind_e kind_of(logic here_set, logic nbr_set);
    if (here_set && !nbr_set) return RUN_LEAD;
    if (nbr_set && !here_set) return RUN_TRAIL;
    return RUN_NONE;
  endfunction

  // Close a run that changes kind and open the new one
  function automatic void track_run(inout run_kind_e kind, inout coord_t start,
                                    input run_kind_e now, input bit along_row,
                                    input int unsigned x, input int unsigned y);
    outline_seg_t s;
    if (now != kind) begin
      if (kind != RUN_NONE) begin
        s.sx = along_row ? start : coord_t'(x);
        s.sy = along_row ? coord_t'(y) : start;
        s.ex = coord_t'(x);
        s.ey = coord_t'(y);
        s.last = 1'b0;
        outline_q.insert(outline_q.size(), s);
      end
      if (now != RUN_NONE) start = along_row ? coord_t'(x) : coord_t'(y);
      kind = now;
    end
  endfunction

  function automatic void predict_outline(logic [PIX_W-1:0] value);
    int unsigned  w;
    int unsigned  h;
    int unsigned  x;
    int unsigned  y;
    int unsigned  depth0;
    logic         closing;
    logic         cur;
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    x = next_col;
    y = next_row;
    depth0 = outline_q.size();
    if (x >= w) x = w - 1;
    if (y > h) y = h;
    closing = (y >= h);
    cur = !closing && (value != '0);

    track_run(line_kind, line_start, kind_of(cur, prev_row_set[x]), 1'b1, x, y);
    track_run(bound_kind[x], bound_start[x],
              kind_of(cur, (x == 0) ? 1'b0 : left_set), 1'b0, x, y);
    prev_row_set[x] = cur;
    left_set = cur;

    // Right border: close the row run and track the rightmost boundary
    if (x + 1 >= w) begin
      track_run(line_kind, line_start, RUN_NONE, 1'b1, w, y);
      track_run(bound_kind[w], bound_start[w], kind_of(1'b0, cur), 1'b0, w, y);
      left_set = 1'b0;
      next_col = 0;
      next_row = closing ? 0 : y + 1;
    end else begin
      next_col = x + 1;
    end

    // Mark the final segment of this pixel
    if (outline_q.size() > depth0) begin
      outline_q[$].last = 1'b1;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Compare each accepted segment and draw the next stall decision
  always @(posedge clk_i) begin
    outline_seg_t want;
    if (rst_ni && seg_bus.valid && seg_bus.ready) begin
      if (outline_q.size() == 0) begin
        $error("segment (%0d,%0d)-(%0d,%0d) arrived with none expected",
               seg_bus.start_x, seg_bus.start_y, seg_bus.end_x, seg_bus.end_y);
        fail_cnt++;
      end else begin
        want = outline_q.pop_front();
        check_field("start_x", want.sx, seg_bus.start_x);
        check_field("start_y", want.sy, seg_bus.start_y);
        check_field("end_x", want.ex, seg_bus.end_x);
        check_field("end_y", want.ey, seg_bus.end_y);
        check_field("last_of_item", want.last, seg_bus.last_of_item);
      end
    end
    seg_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when no request moves on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((pix_bus.valid && pix_bus.ready) || (seg_bus.valid && seg_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_pixel(logic [PIX_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.pixel_value <= value;
    do @(posedge clk_i); while (!pix_bus.ready);
    predict_outline(value);
  endtask

  // Hold the sender until every predicted segment has come out
  task automatic wait_drained();
    pix_bus.valid <= 1'b0;
    while (outline_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, coord_t data, bit hold);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    apply_register(idx, data);
    if (!hold) cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_size(coord_t w, coord_t h);
    wait_drained();
    cfg_write(REG_MASK_WIDTH, w, 1'b1);
    cfg_write(REG_MASK_HEIGHT, h, 1'b0);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(int unsigned dens);
    if ($urandom_range(99) >= dens) return '0;
    case ($urandom_range(3))
      0: return 8'hFF;
      1: return 8'(1 << $urandom_range(7));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Send a frame of the current size; stop early or pause for a drain on request
  task automatic send_frame(int unsigned dens, int pause_at, int stop_at,
                            output int unsigned sent);
    int unsigned total;
    total = clamp_size(width_reg, MAX_W) * (clamp_size(height_reg, MAX_H) + 1);
    sent = 0;
    while (sent < total && int'(sent) != stop_at) begin
      if (int'(sent) == pause_at) wait_drained();
      send_pixel(pick_pixel(dens));
      sent++;
    end
  endtask

  task automatic test_directed();
    logic [PIX_W-1:0] square[12] = '{8'h01, 8'h00, 8'h80,
                                     8'hFF, 8'hFF, 8'h00,
                                     8'h00, 8'hFF, 8'h01,
                                     8'h5A, 8'hFF, 8'h00};
    logic [PIX_W-1:0] stripes[8] = '{8'h40, 8'h00, 8'h10, 8'h08,
                                     8'hFF, 8'hFF, 8'hFF, 8'hFF};
    // Single pixel at reset sizes: set, then clear with a nonzero closing value
    send_pixel(8'h80);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    // Small shape with every edge kind and the closing row ignored
    set_size(7'd3, 7'd2);
    foreach (square[i]) send_pixel(square[i]);
    // One row of set, clear, set, set columns, then a nonzero closing row
    set_size(7'd4, 7'd1);
    foreach (stripes[i]) send_pixel(stripes[i]);
  endtask

  // Mid-frame writes: spare indexes change nothing, a real write restarts the frame
  task automatic test_restart();
    int unsigned sent;
    set_size(7'd5, 7'd4);
    send_frame(60, -1, 7, sent);
    wait_drained();
    cfg_write(REG_SPARE_LO, 7'd9, 1'b1);
    cfg_write(REG_SPARE_HI, 7'h7F, 1'b0);
    send_frame(70, -1, 3, sent);
    set_size(7'd4, 7'd3);
    send_frame(55, -1, -1, sent);
  endtask

  // Zero acts as one, oversize clamps to the maximum
  task automatic test_size_extremes();
    int unsigned sent;
    set_size(7'd0, 7'd0);
    send_frame(100, -1, -1, sent);
    // Full first row at the clamped width, then the start of the closing row
    set_size(7'h7F, 7'd0);
    send_frame(60, -1, 66, sent);
    set_size(7'd1, 7'd100);
    send_frame(50, -1, -1, sent);
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned total;
    int unsigned sel;
    int unsigned dens;
    int          pause_at;
    int          stop_at;
    coord_t      w;
    coord_t      h;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      total = 0;
      while (total < 16) begin
        sel = $urandom_range(19);
        if (sel == 0) begin
          w = coord_t'($urandom_range(9, 16));
          h = coord_t'($urandom_range(0, 1));
        end else if (sel == 1) begin
          w = coord_t'($urandom_range(1, 2));
          h = coord_t'($urandom_range(8, 12));
        end else if (sel == 2) begin
          w = '0;
          h = coord_t'($urandom_range(0, 6));
        end else begin
          w = coord_t'($urandom_range(1, 8));
          h = coord_t'($urandom_range(1, 6));
        end
        set_size(w, h);
        dens = ($urandom_range(4) == 0) ? 100 : $urandom_range(20, 90);
        pause_at = (total == 0 && p == 1) ? 2 : -1;
        stop_at = ($urandom_range(7) == 0) ? $urandom_range(1, 6) : -1;
        send_frame(dens, pause_at, stop_at, sent);
        total += sent;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    fail_cnt = 0;
    idle_pct = 0;
    stall_pct = 0;
    width_reg = 7'd1;
    height_reg = 7'd1;
    restart_frame();
    pix_bus.valid <= 1'b0;
    pix_bus.pixel_value <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_MASK_WIDTH;
    cfg_bus.data <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_restart();
    test_size_extremes();
    test_random();

    wait_drained();
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
